// ===== rtl/iptfs_ipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP-TFS inner packet delineator - shared types and constants
// Payload and result words, header and inner block codes, queue sizing.
// ----------------------------------------------------------------------------
package iptfs_ipd_pkg;

	localparam int BASIC_HEADER_BYTES = 4;
	localparam int CC_HEADER_BYTES    = 24;
	localparam int POSITION_BITS      = 16;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic [7:0] SUBTYPE_CC = 8'h01;
	localparam logic [3:0] TYPE_V4    = 4'h4;   // 0x40 >> 4
	localparam logic [3:0] TYPE_V6    = 4'h6;   // 0x60 >> 4
	localparam logic [2:0] LEN_BYTES  = 3'd2;
	localparam logic [5:0] V6_FIXED   = 6'd40;

	// result queue: power of two deep
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       end_of_packet;
		logic       header_marked_bad;
	} payload_word_t;

	typedef struct packed {
		logic                     record_kind;
		logic [3:0]               block_type;
		logic [POSITION_BITS-1:0] block_start;
		logic [POSITION_BITS-1:0] block_length;
		logic [POSITION_BITS-1:0] block_count;
		logic [POSITION_BITS-1:0] packet_length;
		logic [7:0]               header_subtype;
		logic                     bad_header_seen;
		logic                     bad_decode_seen;
		logic                     straddle_seen;
		logic                     last_of_run;
	} result_word_t;

	typedef struct packed {
		logic rec;   // block record produced
		logic sum;   // packet summary produced
	} push_t;

endpackage
`default_nettype wire

// ===== rtl/iptfs_ipd_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP-TFS delineator walk
// Per-byte header parse and inner block walk; forms record and summary words.
// ----------------------------------------------------------------------------
module iptfs_ipd_walk
	import iptfs_ipd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire payload_word_t word_s1,
	output push_t              push,
	output result_word_t       rec_word,
	output result_word_t       sum_word
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_WAIT   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam int PW = POSITION_BITS;

	logic [PW-1:0] pos_q,    pos_n;
	logic [PW:0]   nbs_q,    nbs_n;
	logic [7:0]    sub_q,    sub_n;
	logic [7:0]    offhi_q,  offhi_n;
	logic [3:0]    type_q,   type_n;
	logic [PW-1:0] start_q,  start_n;
	logic [7:0]    lenhi_q,  lenhi_n;
	logic [2:0]    phase_q,  phase_n;
	logic [PW-1:0] cnt_q,    cnt_n;
	logic          badh_q,   badh_n;
	logic          badd_q,   badd_n;
	logic          strad_q,  strad_n;

	logic [PW:0]   pos17;
	logic [PW:0]   start17;
	logic [5:0]    hdr_cur;
	logic [5:0]    hdr_nxt;
	logic [2:0]    lf_off;
	logic [PW:0]   raw_len;
	logic [PW-1:0] len16;
	logic [PW-1:0] total;
	logic          rec_v;
	logic [PW-1:0] rec_len;
	logic [7:0]    b;

	always_comb begin
		b       = word_s1.payload_byte;
		pos17   = {1'b0, pos_q};
		start17 = {1'b0, start_q};
		hdr_cur = (sub_q == SUBTYPE_CC) ? 6'(CC_HEADER_BYTES) : 6'(BASIC_HEADER_BYTES);
		lf_off  = (type_q == TYPE_V6) ? 3'd4 : 3'd2;
		raw_len = {1'b0, lenhi_q, b} + ((type_q == TYPE_V6) ? (PW+1)'(V6_FIXED) : '0);
		len16   = raw_len[PW] ? POS_MAX : raw_len[PW-1:0];
		total   = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;

		pos_n   = pos_q;
		nbs_n   = nbs_q;
		sub_n   = sub_q;
		offhi_n = offhi_q;
		type_n  = type_q;
		start_n = start_q;
		lenhi_n = lenhi_q;
		phase_n = phase_q;
		badh_n  = badh_q;
		badd_n  = badd_q;
		strad_n = strad_q;
		rec_v   = 1'b0;
		rec_len = '0;

		case (phase_q)
			PH_HEADER: begin
				if (pos_q == '0) begin
					sub_n = b;
					if (word_s1.header_marked_bad) begin
						badh_n  = 1'b1;
						phase_n = PH_DONE;
					end
				end else if (pos_q == PW'(2)) begin
					offhi_n = b;
				end else if (pos_q == PW'(3)) begin
					nbs_n   = (PW+1)'(hdr_cur) + {1'b0, offhi_q, b};
					phase_n = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (pos17 == nbs_q) begin
					type_n  = b[7:4];
					start_n = pos_q;
					if (b[7:4] == TYPE_V4 || b[7:4] == TYPE_V6)
						phase_n = PH_LEN_HI;
					else
						phase_n = PH_PAD;
				end
			end
			PH_LEN_HI: begin
				if (pos17 == start17 + (PW+1)'(lf_off)) begin
					lenhi_n = b;
					phase_n = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				if (pos17 == start17 + (PW+1)'(lf_off) + 1'b1) begin
					rec_v   = 1'b1;
					rec_len = len16;
					if (len16 < PW'(lf_off + LEN_BYTES)) begin
						badd_n  = 1'b1;
						phase_n = PH_DONE;
					end else begin
						nbs_n   = start17 + {1'b0, len16};
						phase_n = PH_WAIT;
					end
				end
			end
			default: begin
			end
		endcase

		hdr_nxt = (sub_n == SUBTYPE_CC) ? 6'(CC_HEADER_BYTES) : 6'(BASIC_HEADER_BYTES);

		if (word_s1.end_of_packet) begin
			// blocks still open at the last byte close here
			if (phase_n == PH_PAD) begin
				rec_v   = 1'b1;
				rec_len = total - start_n;
			end else if (phase_n == PH_LEN_HI || phase_n == PH_LEN_LO) begin
				strad_n = 1'b1;
				rec_v   = 1'b1;
				rec_len = '0;
			end
			if (pos17 + 1'b1 < (PW+1)'(hdr_nxt))
				badh_n = 1'b1;
		end

		cnt_n = (rec_v && cnt_q != POS_MAX) ? cnt_q + 1'b1 : cnt_q;

		rec_word                = '0;
		rec_word.record_kind    = 1'b0;
		rec_word.block_type     = type_n;
		rec_word.block_start    = start_n;
		rec_word.block_length   = rec_len;
		rec_word.last_of_run    = !word_s1.end_of_packet;

		sum_word                 = '0;
		sum_word.record_kind     = 1'b1;
		sum_word.block_count     = cnt_n;
		sum_word.packet_length   = total;
		sum_word.header_subtype  = sub_n;
		sum_word.bad_header_seen = badh_n;
		sum_word.bad_decode_seen = badd_n;
		sum_word.straddle_seen   = strad_n;
		sum_word.last_of_run     = 1'b1;

		push.rec = step && rec_v;
		push.sum = step && word_s1.end_of_packet;

		if (!word_s1.end_of_packet)
			pos_n = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			nbs_q   <= '0;
			sub_q   <= '0;
			offhi_q <= '0;
			type_q  <= '0;
			start_q <= '0;
			lenhi_q <= '0;
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			badh_q  <= 1'b0;
			badd_q  <= 1'b0;
			strad_q <= 1'b0;
		end else if (step) begin
			if (word_s1.end_of_packet) begin
				// summary out, back to the start of a payload
				pos_q   <= '0;
				nbs_q   <= '0;
				sub_q   <= '0;
				offhi_q <= '0;
				type_q  <= '0;
				start_q <= '0;
				lenhi_q <= '0;
				phase_q <= PH_HEADER;
				cnt_q   <= '0;
				badh_q  <= 1'b0;
				badd_q  <= 1'b0;
				strad_q <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				nbs_q   <= nbs_n;
				sub_q   <= sub_n;
				offhi_q <= offhi_n;
				type_q  <= type_n;
				start_q <= start_n;
				lenhi_q <= lenhi_n;
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				badh_q  <= badh_n;
				badd_q  <= badd_n;
				strad_q <= strad_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/iptfs_ipd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP-TFS delineator result queue
// Small queue taking up to two words a cycle, giving one word a cycle while result_ready is high.
// ----------------------------------------------------------------------------
module iptfs_ipd_outq
	import iptfs_ipd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire push_t        push,
	input  wire result_word_t rec_word,
	input  wire result_word_t sum_word,
	output logic              room,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_word_t      result_data
);

	result_word_t      mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic [QPTR_W-1:0] wptr1;
	logic [1:0]        n_push;
	logic              pop;
	result_word_t      wr0;

	assign wptr1        = wptr_q + 1'b1;
	assign n_push       = {1'b0, push.rec} + {1'b0, push.sum};
	assign wr0          = push.rec ? rec_word : sum_word;
	assign result_valid = (cnt_q != '0);
	assign result_data  = mem_q[rptr_q];
	assign pop          = result_valid && result_ready;
	// two free slots guarantee a whole byte's results fit
	assign room         = (cnt_q <= (QPTR_W+1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wptr_q] <= wr0;
		if (n_push == 2'd2)
			mem_q[wptr1] <= sum_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QPTR_W'(n_push);
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/iptfs_inner_packet_delineator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP-TFS inner packet delineator core
// Walks one IP-TFS payload a byte at a time, emits a record per inner packet
// and a summary word on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                     | word
//  ---------+-------------------------------+-------------------------------
//  payload  | payload_valid / payload_ready | payload_data (payload_word_t)
//  result   | result_valid / result_ready   | result_data  (result_word_t)
//
// One payload byte per cycle while the queue has room. A byte waits in the input
// register until the queue has room, is walked, and its results are written into a
// four-word queue that drives the result port.
// A byte leaves the input register only with two free queue slots, so a
// stalled result side backs up into payload_ready once more than two words wait.
// Reset clears the walk state and empties the queue; no clearing pass.
//
module iptfs_inner_packet_delineator_core
	import iptfs_ipd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          payload_valid,
	output logic               payload_ready,
	input  wire payload_word_t payload_data,
	output logic               result_valid,
	input  wire logic          result_ready,
	output result_word_t       result_data
);

	payload_word_t word_s1;   // byte waiting to be walked
	logic          valid_s1;
	logic          room;      // queue can take a full byte's results
	logic          step;      // walk the byte in the input register
	push_t         push;
	result_word_t  rec_word;
	result_word_t  sum_word;

	assign step          = valid_s1 && room;
	// input register refills in the cycle it drains
	assign payload_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload_ready) begin
			valid_s1 <= payload_valid;
		end
	end

	// payload bits need no reset
	always_ff @(posedge clk) begin
		if (payload_ready && payload_valid)
			word_s1 <= payload_data;
	end

	iptfs_ipd_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.word_s1  (word_s1),
		.push     (push),
		.rec_word (rec_word),
		.sum_word (sum_word)
	);

	iptfs_ipd_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rec_word     (rec_word),
		.sum_word     (sum_word),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire
